@@ rtl/core/lesf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_pkg
// Shared constants, codes and types of the largest empty square finder.
// ----------------------------------------------------------------------------
package lesf_pkg;

    localparam int MAX_COLS   = 1024;
    localparam int MAX_HITS   = 32;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int SIZE_W     = $clog2(MAX_COLS + 1);
    localparam int ROW_W      = 16;
    localparam int FLD_SIZE_W = 11;
    localparam int TOTAL_W    = 16;
    localparam int KEY_W      = FLD_SIZE_W + ROW_W;
    localparam int LIST_W     = $clog2(MAX_HITS + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_COLS_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic REC_HEADER   = 1'b0;
    localparam logic REC_POSITION = 1'b1;

    typedef logic [KEY_W-1:0] t_key;

    typedef struct packed {
        logic ins;
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

@@ rtl/core/lesf_cell_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_cell_if
// Grid cell stream: one blocked/empty bit per request.
// ----------------------------------------------------------------------------
interface lesf_cell_if ();
    logic valid;
    logic ready;
    logic cell_blocked;

    modport source (output valid, output cell_blocked, input ready);
    modport sink (input valid, input cell_blocked, output ready);
endinterface

@@ rtl/core/lesf_rec_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_rec_if
// Report record stream: a header request followed by position requests.
// ----------------------------------------------------------------------------
interface lesf_rec_if import lesf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  record_kind;
    logic [FLD_SIZE_W-1:0] square_size;
    logic [TOTAL_W-1:0]    hit_total;
    logic [FLD_SIZE_W-1:0] left_column;
    logic [ROW_W-1:0]      bottom_row_up;
    logic                  list_overflow;
    logic                  last_record;

    modport source (
        output valid, output record_kind, output square_size, output hit_total,
        output left_column, output bottom_row_up, output list_overflow,
        output last_record, input ready
    );
    modport sink (
        input valid, input record_kind, input square_size, input hit_total,
        input left_column, input bottom_row_up, input list_overflow,
        input last_record, output ready
    );
endinterface

@@ rtl/core/largest_empty_square_finder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// largest_empty_square_finder_unit
// Streams grid cells, tracks the largest empty square and reports its hits.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_cell    in         cell_blocked
//  o_rec     out        record_kind, square_size, hit_total, left_column,
//                       bottom_row_up, list_overflow, last_record
//  i_cfg_*   in         register write: index, data
//
//  One cell is taken per cycle; the size, the line buffer and the list insert
//  all complete in the cycle the cell is taken.
//  A report of one header and up to MAX_HITS positions leaves one per cycle
//  from its own shift line whenever o_rec is ready, while the next scan keeps running.
//  The last cell of a scan waits only while the previous report is draining;
//  it is taken in the same cycle as the final record of that report.
//  Reset is synchronous; the line buffer is not cleared, row 0 rewrites it.
// ----------------------------------------------------------------------------
module largest_empty_square_finder_unit import lesf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lesf_cell_if.sink             i_cell,
    lesf_rec_if.source            o_rec
);

    logic [ROW_W-1:0]   r_rows;
    logic [ROW_W-1:0]   r_last_row;
    logic [COL_W-1:0]   r_last_col;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [SIZE_W-1:0]  r_left;
    logic [SIZE_W-1:0]  r_diag;
    logic [SIZE_W-1:0]  r_best;
    logic [TOTAL_W-1:0] r_hits;
    logic               r_ovf;

    logic               r_rep_busy;
    logic               r_rep_hdr;
    logic [LIST_W-1:0]  r_rep_left;
    logic [SIZE_W-1:0]  r_rep_size;
    logic [TOTAL_W-1:0] r_rep_total;
    logic               r_rep_ovf;

    logic [CFG_COLS_W-1:0] cfg_cols;
    logic [SIZE_W-1:0]     eff_cols;
    logic [ROW_W-1:0]      eff_rows;

    logic               last_col;
    logic               last_cell;
    logic               in_fire;
    logic               out_fire;
    logic [SIZE_W-1:0]  lb_rdata;
    logic [COL_W-1:0]   lb_raddr;
    logic [SIZE_W-1:0]  up;
    logic [SIZE_W-1:0]  min_lu;
    logic [SIZE_W-1:0]  min_all;
    logic [SIZE_W-1:0]  size;
    logic               cand;
    logic               new_best;
    logic               match;
    logic [SIZE_W-1:0]  left_col;
    t_key               key;
    logic [LIST_W-1:0]  stored;
    logic [SIZE_W-1:0]  n_best;
    logic [TOTAL_W-1:0] n_hits;
    logic               n_ovf;
    logic [LIST_W-1:0]  n_stored;
    t_cell_ctl          cell_ctl;

    logic               w_valid  [MAX_HITS];
    logic               w_at_end [MAX_HITS];
    logic               w_gt     [MAX_HITS];
    t_key               w_entry  [MAX_HITS];
    t_key               w_rep    [MAX_HITS];

    assign cfg_cols = i_cfg_data[CFG_COLS_W-1:0];

    always_comb begin
        if (cfg_cols == '0) begin
            eff_cols = SIZE_W'(1);
        end else if (32'(cfg_cols) > MAX_COLS) begin
            eff_cols = SIZE_W'(MAX_COLS);
        end else begin
            eff_cols = SIZE_W'(cfg_cols);
        end
        eff_rows = (i_cfg_data == '0) ? ROW_W'(1) : i_cfg_data;
    end

    assign last_col  = (r_col == r_last_col);
    assign last_cell = last_col && (r_row == r_last_row);

    assign out_fire     = o_rec.valid && o_rec.ready;
    assign i_cell.ready = !(r_rep_busy && last_cell) || (out_fire && o_rec.last_record);
    assign in_fire      = i_cell.valid && i_cell.ready;

    always_comb begin
        if (in_fire) begin
            lb_raddr = last_col ? '0 : r_col + COL_W'(1);
        end else begin
            lb_raddr = r_col;
        end
    end

    lesf_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_we    (in_fire),
        .i_waddr (r_col),
        .i_wdata (size),
        .i_raddr (lb_raddr),
        .o_rdata (lb_rdata)
    );

    always_comb begin
        up      = (r_row == '0) ? '0 : lb_rdata;
        min_lu  = (r_left < up) ? r_left : up;
        min_all = (r_diag < min_lu) ? r_diag : min_lu;
        if (i_cell.cell_blocked) begin
            size = '0;
        end else if (r_row == '0 || r_col == '0) begin
            size = SIZE_W'(1);
        end else begin
            size = min_all + SIZE_W'(1);
        end
        cand     = !i_cell.cell_blocked && (r_row != '0) && (r_col != '0);
        new_best = cand && (size > r_best);
        match    = cand && (size >= r_best);
        left_col = SIZE_W'(r_col) + SIZE_W'(2) - size;
        key      = {FLD_SIZE_W'(left_col), r_rows - r_row};
        stored   = (r_hits >= TOTAL_W'(MAX_HITS)) ? LIST_W'(MAX_HITS)
                                                  : LIST_W'(r_hits);
    end

    always_comb begin
        n_best = r_best;
        n_hits = r_hits;
        n_ovf  = r_ovf;
        if (new_best) begin
            n_best = size;
            n_hits = TOTAL_W'(1);
            n_ovf  = 1'b0;
        end else if (match) begin
            if (r_hits != '1) begin
                n_hits = r_hits + TOTAL_W'(1);
            end
            if (stored == LIST_W'(MAX_HITS)) begin
                n_ovf = 1'b1;
            end
        end
        n_stored = (n_hits >= TOTAL_W'(MAX_HITS)) ? LIST_W'(MAX_HITS)
                                                  : LIST_W'(n_hits);
    end

    assign cell_ctl.ins   = in_fire && match;
    assign cell_ctl.load  = in_fire && last_cell;
    assign cell_ctl.shift = out_fire && !r_rep_hdr;

    for (genvar i = 0; i < MAX_HITS; i++) begin : g_cell
        assign w_valid[i] = !new_best && (LIST_W'(i) < stored);

        if (i == 0) begin : g_head
            assign w_at_end[i] = !w_valid[i];
            lesf_hit_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_key        (key),
                .i_valid      (w_valid[i]),
                .i_at_end     (w_at_end[i]),
                .i_prev_gt    (1'b0),
                .i_prev_entry (key),
                .i_next_rep   ((MAX_HITS > 1) ? w_rep[(MAX_HITS > 1) ? 1 : 0] : w_rep[0]),
                .o_gt         (w_gt[i]),
                .o_entry      (w_entry[i]),
                .o_rep        (w_rep[i])
            );
        end else begin : g_body
            assign w_at_end[i] = !w_valid[i] && w_valid[i-1];
            lesf_hit_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (cell_ctl),
                .i_key        (key),
                .i_valid      (w_valid[i]),
                .i_at_end     (w_at_end[i]),
                .i_prev_gt    (w_gt[i-1]),
                .i_prev_entry (w_entry[i-1]),
                .i_next_rep   ((i + 1 < MAX_HITS) ? w_rep[(i + 1 < MAX_HITS) ? i + 1 : i]
                                                  : w_rep[i]),
                .o_gt         (w_gt[i]),
                .o_entry      (w_entry[i]),
                .o_rep        (w_rep[i])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= ROW_W'(1);
            r_last_row <= '0;
            r_last_col <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_left     <= '0;
            r_diag     <= '0;
            r_best     <= '0;
            r_hits     <= '0;
            r_ovf      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS: begin
                    r_rows     <= eff_rows;
                    r_last_row <= eff_rows - ROW_W'(1);
                end
                CFG_COLS: begin
                    r_last_col <= COL_W'(eff_cols - SIZE_W'(1));
                end
                default: begin
                end
            endcase
            r_row  <= '0;
            r_col  <= '0;
            r_left <= '0;
            r_diag <= '0;
            r_best <= '0;
            r_hits <= '0;
            r_ovf  <= 1'b0;
        end else if (in_fire) begin
            if (last_col) begin
                r_col  <= '0;
                r_left <= '0;
                r_diag <= '0;
            end else begin
                r_col  <= r_col + COL_W'(1);
                r_left <= size;
                r_diag <= up;
            end
            if (last_cell) begin
                r_row  <= '0;
                r_best <= '0;
                r_hits <= '0;
                r_ovf  <= 1'b0;
            end else begin
                if (last_col) begin
                    r_row <= r_row + ROW_W'(1);
                end
                r_best <= n_best;
                r_hits <= n_hits;
                r_ovf  <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_busy <= 1'b0;
            r_rep_hdr  <= 1'b0;
            r_rep_left <= '0;
        end else if (cell_ctl.load) begin
            r_rep_busy <= 1'b1;
            r_rep_hdr  <= 1'b1;
            r_rep_left <= n_stored;
        end else if (out_fire) begin
            if (r_rep_hdr) begin
                r_rep_hdr <= 1'b0;
                if (r_rep_left == '0) begin
                    r_rep_busy <= 1'b0;
                end
            end else begin
                r_rep_left <= r_rep_left - LIST_W'(1);
                if (r_rep_left == LIST_W'(1)) begin
                    r_rep_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctl.load) begin
            r_rep_size  <= n_best;
            r_rep_total <= n_hits;
            r_rep_ovf   <= n_ovf;
        end
    end

    always_comb begin
        o_rec.valid         = r_rep_busy;
        o_rec.square_size   = FLD_SIZE_W'(r_rep_size);
        o_rec.hit_total     = r_rep_total;
        o_rec.list_overflow = r_rep_ovf;
        if (r_rep_hdr) begin
            o_rec.record_kind   = REC_HEADER;
            o_rec.left_column   = '0;
            o_rec.bottom_row_up = '0;
            o_rec.last_record   = (r_rep_left == '0);
        end else begin
            o_rec.record_kind   = REC_POSITION;
            o_rec.left_column   = w_rep[0][KEY_W-1:ROW_W];
            o_rec.bottom_row_up = w_rep[0][ROW_W-1:0];
            o_rec.last_record   = (r_rep_left == LIST_W'(1));
        end
    end

`ifndef ASSERT_OFF
    a_stall_only_on_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cell.ready |-> r_rep_busy && last_cell)
        else $error("cell input stalled without a pending report");

    a_hdr_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_hdr |-> r_rep_busy)
        else $error("report header pending while report idle");

    a_positions_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_busy && !r_rep_hdr |-> r_rep_left != '0)
        else $error("position request shown with no entries left");

    a_best_has_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best != '0) == (r_hits != '0))
        else $error("best size and hit count disagree");

    a_ovf_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_hits > TOTAL_W'(MAX_HITS))
        else $error("overflow flagged with the hit list not exceeded");
`endif

endmodule

@@ rtl/core/lesf_line_buf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_line_buf
// Previous-row line buffer of square sizes, one write and one read port.
// ----------------------------------------------------------------------------
module lesf_line_buf import lesf_pkg::*; (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [COL_W-1:0]  i_waddr,
    input  logic [SIZE_W-1:0] i_wdata,
    input  logic [COL_W-1:0]  i_raddr,
    output logic [SIZE_W-1:0] o_rdata
);

    logic [SIZE_W-1:0] r_mem [MAX_COLS];
    logic [SIZE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/lesf_hit_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lesf_hit_cell
// One slot of the sorted hit list and of the report shift line.
// ----------------------------------------------------------------------------
module lesf_hit_cell import lesf_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_key      i_key,
    input  logic      i_valid,
    input  logic      i_at_end,
    input  logic      i_prev_gt,
    input  t_key      i_prev_entry,
    input  t_key      i_next_rep,
    output logic      o_gt,
    output t_key      o_entry,
    output t_key      o_rep
);

    t_key r_entry;
    t_key n_entry;
    t_key r_rep;
    t_key n_rep;

    assign o_gt = i_valid && (r_entry > i_key);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (o_gt || i_at_end) begin
                n_entry = i_prev_gt ? i_prev_entry : i_key;
            end
        end
    end

    always_comb begin
        n_rep = r_rep;
        if (i_ctl.load) begin
            n_rep = n_entry;
        end else if (i_ctl.shift) begin
            n_rep = i_next_rep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_rep   <= n_rep;
    end

    assign o_entry = r_entry;
    assign o_rep   = r_rep;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for largest_empty_square_finder_unit. Grid scans are
// streamed in under random gaps while the report side stalls at random. Every
// cell request feeds a predictor of square sizes, best size and the sorted hit
// list, and each report request is compared field by field with the oldest
// predicted record.
// ----------------------------------------------------------------------------
package lesf_tb_pkg;
    import lesf_pkg::*;

    typedef struct packed {
        logic                  record_kind;
        logic [FLD_SIZE_W-1:0] square_size;
        logic [TOTAL_W-1:0]    hit_total;
        logic [FLD_SIZE_W-1:0] left_column;
        logic [ROW_W-1:0]      bottom_row_up;
        logic                  list_overflow;
        logic                  last_record;
    } t_record;

    class square_scoreboard;
        bit [ROW_W-1:0]      rows_word;
        bit [CFG_COLS_W-1:0] cols_word;
        bit [FLD_SIZE_W-1:0] line_sizes[MAX_COLS];
        bit [FLD_SIZE_W-1:0] left_sz;
        bit [FLD_SIZE_W-1:0] diag_sz;
        bit [FLD_SIZE_W-1:0] best_sz;
        bit [ROW_W-1:0]      row_pos;
        bit [COL_W-1:0]      col_pos;
        bit [TOTAL_W-1:0]    hits;
        t_key                hit_keys[MAX_HITS];
        bit                  overflow;
        t_record             due_records[$];
        int unsigned         mismatches;
        int unsigned         records_seen;

        function new();
            rows_word = 1;
            cols_word = 1;
            mismatches = 0;
            records_seen = 0;
            foreach (line_sizes[i]) line_sizes[i] = '0;
            restart();
        endfunction

        function void restart();
            left_sz = '0;
            diag_sz = '0;
            row_pos = '0;
            col_pos = '0;
            best_sz = '0;
            hits = '0;
            overflow = 1'b0;
            foreach (hit_keys[i]) hit_keys[i] = '0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("MISMATCH %s", what);
        endtask

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_ROWS: begin
                    rows_word = data[ROW_W-1:0];
                    restart();
                end
                CFG_COLS: begin
                    cols_word = data[CFG_COLS_W-1:0];
                    restart();
                end
                default: ;
            endcase
        endfunction

        // A full list only takes a square that sorts before its last entry.
        function void add_hit(t_key key);
            int unsigned stored;
            int unsigned pos;
            stored = (hits < MAX_HITS) ? hits : MAX_HITS;
            if (hits != {TOTAL_W{1'b1}}) hits++;
            if (stored >= MAX_HITS) begin
                overflow = 1'b1;
                if (key >= hit_keys[MAX_HITS-1]) return;
                stored = MAX_HITS - 1;
            end
            pos = stored;
            while (pos > 0 && hit_keys[pos-1] > key) begin
                hit_keys[pos] = hit_keys[pos-1];
                pos--;
            end
            hit_keys[pos] = key;
        endfunction

        function void take_cell(logic blocked);
            int unsigned n_rows, n_cols, c, r, up, sz, listed, k;
            t_key key;
            t_record rec;
            n_rows = (rows_word == 0) ? 1 : rows_word;
            n_cols = (cols_word == 0) ? 1 : ((cols_word > MAX_COLS) ? MAX_COLS : cols_word);
            c = col_pos;
            r = row_pos;
            if (c >= n_cols) c = n_cols - 1;
            up = (r == 0) ? 0 : line_sizes[c];
            if (blocked) begin
                sz = 0;
            end else if (r == 0 || c == 0) begin
                sz = 1;
            end else begin
                sz = up;
                if (left_sz < sz) sz = left_sz;
                if (diag_sz < sz) sz = diag_sz;
                sz++;
            end
            if (!blocked && r != 0 && c != 0) begin
                key = {FLD_SIZE_W'(c + 2 - sz), ROW_W'(n_rows - r)};
                if (sz > best_sz) begin
                    best_sz = sz;
                    hits = '0;
                    overflow = 1'b0;
                end
                if (sz == best_sz) add_hit(key);
            end
            diag_sz = up;
            line_sizes[c] = sz;
            left_sz = sz;
            if (c + 1 >= n_cols) begin
                col_pos = '0;
                left_sz = '0;
                diag_sz = '0;
                if (r + 1 >= n_rows) begin
                    listed = (hits < MAX_HITS) ? hits : MAX_HITS;
                    rec.record_kind = REC_HEADER;
                    rec.square_size = best_sz;
                    rec.hit_total = hits;
                    rec.left_column = '0;
                    rec.bottom_row_up = '0;
                    rec.list_overflow = overflow;
                    rec.last_record = (listed == 0);
                    due_records.push_back(rec);
                    for (k = 0; k < listed; k++) begin
                        rec.record_kind = REC_POSITION;
                        rec.left_column = hit_keys[k][KEY_W-1:ROW_W];
                        rec.bottom_row_up = hit_keys[k][ROW_W-1:0];
                        rec.last_record = (k + 1 == listed);
                        due_records.push_back(rec);
                    end
                    restart();
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
            end
        endfunction

        task compare_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want) begin
                report_mismatch($sformatf("record %0d, %s: got %0h, expected %0h",
                                          records_seen, name, got, want));
            end
        endtask

        task check_record(t_record got);
            t_record want;
            records_seen++;
            if (due_records.size() == 0) begin
                report_mismatch($sformatf("record %0d arrived with none expected",
                                          records_seen));
                return;
            end
            want = due_records.pop_front();
            compare_field("record_kind", got.record_kind, want.record_kind);
            compare_field("square_size", got.square_size, want.square_size);
            compare_field("hit_total", got.hit_total, want.hit_total);
            compare_field("left_column", got.left_column, want.left_column);
            compare_field("bottom_row_up", got.bottom_row_up, want.bottom_row_up);
            compare_field("list_overflow", got.list_overflow, want.list_overflow);
            compare_field("last_record", got.last_record, want.last_record);
        endtask
    endclass
endpackage

module testbench;
    import lesf_pkg::*;
    import lesf_tb_pkg::*;

    typedef enum int {
        PAT_RANDOM,
        PAT_LATTICE,
        PAT_OPEN,
        PAT_WALL,
        PAT_TOP,
        PAT_EDGE
    } t_pattern;

    localparam int unsigned ALL_CELLS    = 32'hFFFF_FFFF;
    localparam int unsigned RANDOM_CELLS = 210;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lesf_cell_if cell_bus ();
    lesf_rec_if  rec_bus ();

    square_scoreboard sb = new();
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned cells_sent = 0;
    logic [CFG_DATA_W-1:0] rows_now = 16'd1;
    logic [CFG_DATA_W-1:0] cols_now = 16'd1;

    largest_empty_square_finder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (cell_bus),
        .o_rec      (rec_bus)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #500_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned gap_length();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) return $urandom_range(1, 3);
        if (pick < 9) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    function automatic logic make_cell(t_pattern pat, int unsigned r, int unsigned c,
                                       int unsigned n_cols, int unsigned density);
        case (pat)
            PAT_LATTICE: return (r % 2 == 0) && (c % 2 == 0);
            PAT_OPEN:    return 1'b0;
            PAT_WALL:    return 1'b1;
            PAT_TOP:     return (r >= 6) || ($urandom_range(0, 99) < density);
            PAT_EDGE:    return c != n_cols - 1;
            default:     return $urandom_range(0, 99) < density;
        endcase
    endfunction

    function automatic int unsigned eff_rows(logic [CFG_DATA_W-1:0] w);
        return (w == 0) ? 1 : w;
    endfunction

    function automatic int unsigned eff_cols(logic [CFG_DATA_W-1:0] w);
        int unsigned v;
        v = w[CFG_COLS_W-1:0];
        return (v == 0) ? 1 : ((v > MAX_COLS) ? MAX_COLS : v);
    endfunction

    // Report side: ready drops for random stretches.
    initial begin : rec_ready_gen
        int unsigned hold;
        hold = 0;
        rec_bus.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                rec_bus.ready <= 1'b0;
                hold--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                rec_bus.ready <= 1'b0;
                hold = gap_length() - 1;
            end else begin
                rec_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_record seen;
        if (i_rst_n) begin
            if (i_cfg_we) sb.write_register(i_cfg_idx, i_cfg_data);
            if (cell_bus.valid && cell_bus.ready) sb.take_cell(cell_bus.cell_blocked);
            if (rec_bus.valid && rec_bus.ready) begin
                seen = {rec_bus.record_kind, rec_bus.square_size, rec_bus.hit_total,
                        rec_bus.left_column, rec_bus.bottom_row_up, rec_bus.list_overflow,
                        rec_bus.last_record};
                sb.check_record(seen);
            end
        end
    end

    task automatic send_cell(input logic blocked);
        int unsigned gap;
        gap = ($urandom_range(0, 99) < gap_pct) ? gap_length() : 0;
        if (gap > 0) begin
            @(negedge i_clk) cell_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cell_bus.valid <= 1'b1;
        cell_bus.cell_blocked <= blocked;
        do @(posedge i_clk); while (!cell_bus.ready);
        cells_sent++;
    endtask

    task automatic run_scan(input int unsigned n_rows, input int unsigned n_cols,
                            input t_pattern pat, input int unsigned density,
                            input int unsigned stop_after);
        int unsigned r, c, n;
        n = 0;
        for (r = 0; r < n_rows && n < stop_after; r++) begin
            for (c = 0; c < n_cols && n < stop_after; c++) begin
                send_cell(make_cell(pat, r, c, n_cols, density));
                n++;
            end
        end
        @(negedge i_clk) cell_bus.valid <= 1'b0;
    endtask

    // Registers change only with no report pending and the pipeline quiet.
    task automatic settle();
        while (sb.due_records.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk) i_cfg_we <= 1'b0;
        if (idx == CFG_ROWS) rows_now = data;
        else cols_now = data;
    endtask

    task automatic set_grid(input logic [CFG_DATA_W-1:0] rows_w,
                            input logic [CFG_DATA_W-1:0] cols_w);
        settle();
        write_reg(CFG_ROWS, rows_w);
        write_reg(CFG_COLS, cols_w);
    endtask

    initial begin : stimulus
        int unsigned random_start, n_scans, s, cells, stop, sel, density, i, budget;
        logic [CFG_DATA_W-1:0] rows_w, cols_w;
        t_pattern pat;

        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_ROWS;
        i_cfg_data <= '0;
        cell_bus.valid <= 1'b0;
        cell_bus.cell_blocked <= 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed: reset grid, out-of-range and masked registers, restart mid-scan.
        run_scan(1, 1, PAT_OPEN, 0, ALL_CELLS);
        run_scan(1, 1, PAT_WALL, 0, ALL_CELLS);
        set_grid(16'd0, 16'hF803);
        run_scan(1, 3, PAT_RANDOM, 50, ALL_CELLS);
        set_grid(16'd3, 16'd3);
        run_scan(3, 3, PAT_OPEN, 0, 4);
        settle();
        write_reg(CFG_ROWS, 16'd3);
        run_scan(3, 3, PAT_OPEN, 0, ALL_CELLS);

        // Extremes: clamped width, an overflowing hit list, a large open square.
        gap_pct = 3;
        stall_pct = 20;
        set_grid(16'd2, 16'hFFFF);
        run_scan(2, MAX_COLS, PAT_OPEN, 0, 20);
        set_grid(16'd8, 16'd10);
        run_scan(8, 10, PAT_LATTICE, 0, ALL_CELLS);
        set_grid(16'd10, 16'd4);
        run_scan(10, 4, PAT_TOP, 40, ALL_CELLS);
        set_grid(16'd3, 16'd8);
        run_scan(3, 8, PAT_EDGE, 0, ALL_CELLS);
        set_grid(16'd6, 16'd6);
        run_scan(6, 6, PAT_OPEN, 0, ALL_CELLS);
        stall_pct = 0;
        set_grid(16'd0, 16'd0);
        run_scan(1, 1, PAT_OPEN, 0, ALL_CELLS);

        random_start = cells_sent;
        while (cells_sent - random_start < RANDOM_CELLS) begin
            rows_w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
            sel = $urandom_range(0, 19);
            cols_w = (sel == 0) ? 16'd0 :
                     ((sel < 3) ? 16'($urandom_range(13, 40)) : 16'($urandom_range(1, 12)));
            cols_w[15:CFG_COLS_W] = 5'($urandom);
            settle();
            case ($urandom_range(0, 3))
                0: write_reg(CFG_ROWS, rows_w);
                1: write_reg(CFG_COLS, cols_w);
                default: begin
                    write_reg(CFG_COLS, cols_w);
                    write_reg(CFG_ROWS, rows_w);
                end
            endcase
            sel = $urandom_range(0, 2);
            gap_pct = (sel == 0) ? 0 : ((sel == 1) ? 15 : 40);
            sel = $urandom_range(0, 2);
            stall_pct = (sel == 0) ? 0 : ((sel == 1) ? 15 : 50);
            n_scans = $urandom_range(1, 3);
            cells = eff_rows(rows_now) * eff_cols(cols_now);
            for (s = 0; s < n_scans && cells_sent - random_start < RANDOM_CELLS; s++) begin
                sel = $urandom_range(0, 9);
                pat = (sel == 0) ? PAT_LATTICE :
                      ((sel == 1) ? PAT_OPEN : ((sel == 2) ? PAT_WALL : PAT_RANDOM));
                sel = $urandom_range(0, 3);
                density = (sel == 0) ? 5 : ((sel == 1) ? 20 : ((sel == 2) ? 40 : 70));
                stop = ALL_CELLS;
                if (s + 1 == n_scans && cells > 1 && $urandom_range(0, 6) == 0) begin
                    stop = $urandom_range(1, cells - 1);
                end
                budget = RANDOM_CELLS - (cells_sent - random_start);
                if (stop > budget) stop = budget;
                run_scan(eff_rows(rows_now), eff_cols(cols_now), pat, density, stop);
            end
        end

        for (i = 0; i < 100000 && sb.due_records.size() != 0; i++) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (sb.due_records.size() != 0) begin
            sb.report_mismatch($sformatf("%0d records never arrived", sb.due_records.size()));
        end
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/core/lesf_pkg.sv
rtl/core/lesf_cell_if.sv
rtl/core/lesf_rec_if.sv
rtl/core/lesf_line_buf.sv
rtl/core/lesf_hit_cell.sv
rtl/core/largest_empty_square_finder_unit.sv
bench/testbench.sv
